### rtl/core/fdct_pkg.sv
// Package for the 8x8 slow-integer forward DCT block.
// Holds payload structs, FSM states, fixed-point constants and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fdct_pkg;

  localparam int unsigned FRAC_BITS  = 13;
  localparam int unsigned PASS1_BITS = 2;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned RAM_DEPTH  = 128;

  localparam logic signed [15:0] C_0298 = 16'sd2446;
  localparam logic signed [15:0] C_0390 = 16'sd3196;
  localparam logic signed [15:0] C_0541 = 16'sd4433;
  localparam logic signed [15:0] C_0765 = 16'sd6270;
  localparam logic signed [15:0] C_0899 = 16'sd7373;
  localparam logic signed [15:0] C_1175 = 16'sd9633;
  localparam logic signed [15:0] C_1501 = 16'sd12299;
  localparam logic signed [15:0] C_1847 = 16'sd15137;
  localparam logic signed [15:0] C_1961 = 16'sd16069;
  localparam logic signed [15:0] C_2053 = 16'sd16819;
  localparam logic signed [15:0] C_2562 = 16'sd20995;
  localparam logic signed [15:0] C_3072 = 16'sd25172;

  typedef logic [7:0][15:0] vec_t;

  typedef struct packed {
    logic signed [7:0] sample0;
    logic signed [7:0] sample1;
    logic signed [7:0] sample2;
    logic signed [7:0] sample3;
    logic signed [7:0] sample4;
    logic signed [7:0] sample5;
    logic signed [7:0] sample6;
    logic signed [7:0] sample7;
  } req_t;

  typedef struct packed {
    logic signed [15:0] coef0;
    logic signed [15:0] coef1;
    logic signed [15:0] coef2;
    logic signed [15:0] coef3;
    logic signed [15:0] coef4;
    logic signed [15:0] coef5;
    logic signed [15:0] coef6;
    logic signed [15:0] coef7;
    logic [2:0]         freq_row;
    logic               block_done;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_WR,
    ST_GATHER,
    ST_OUTRD,
    ST_EMIT
  } state_e;

  function automatic logic signed [33:0] mulc(input logic signed [15:0] a,
                                              input logic signed [15:0] c);
    mulc = 34'(a) * 34'(c);
  endfunction

  // Round half up, arithmetic shift, keep low 16 bits.
  function automatic logic [15:0] descale(input logic signed [33:0] v,
                                          input logic second);
    logic signed [33:0] s;
    logic signed [33:0] r;
    s = second ? v + 34'sd16384 : v + 34'sd1024;
    r = second ? (s >>> (FRAC_BITS + PASS1_BITS)) : (s >>> (FRAC_BITS - PASS1_BITS));
    descale = r[15:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/fdct_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fdct_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/fdct_core.sv
// Three-stage 8-point Loeffler DCT unit: butterflies, constant products, sums.
// Used for both row and column passes. Depends on fdct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fdct_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic            second_i,
  input  wire fdct_pkg::vec_t  vec_i,
  output logic                 valid_o,
  output fdct_pkg::vec_t       vec_o
);
  logic signed [15:0] d [8];
  logic signed [15:0] t0, t1, t2, t3, t4, t5, t6, t7, t10, t11, t12, t13;
  logic v1_q, v2_q, v3_q, sec1_q, sec2_q;
  logic signed [15:0] t4_q, t5_q, t6_q, t7_q, t12_q, t13_q, za_q, zb_q, dc0_q, dc4_q;
  logic signed [15:0] dc0b_q, dc4b_q;
  logic signed [33:0] p_q [16];
  logic signed [33:0] z3, z4;
  logic signed [15:0] e0, e4;

  for (genvar i = 0; i < 8; i++) begin : g_in
    assign d[i] = vec_i[i];
  end

  assign t0  = d[0] + d[7];
  assign t7  = d[0] - d[7];
  assign t1  = d[1] + d[6];
  assign t6  = d[1] - d[6];
  assign t2  = d[2] + d[5];
  assign t5  = d[2] - d[5];
  assign t3  = d[3] + d[4];
  assign t4  = d[3] - d[4];
  assign t10 = t0 + t3;
  assign t13 = t0 - t3;
  assign t11 = t1 + t2;
  assign t12 = t1 - t2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sec1_q <= second_i;
      t4_q   <= t4;
      t5_q   <= t5;
      t6_q   <= t6;
      t7_q   <= t7;
      t12_q  <= t12;
      t13_q  <= t13;
      za_q   <= t4 + t6;
      zb_q   <= t5 + t7;
      dc0_q  <= t10 + t11;
      dc4_q  <= t10 - t11;
    end
    if (v1_q) begin
      sec2_q  <= sec1_q;
      dc0b_q  <= dc0_q;
      dc4b_q  <= dc4_q;
      p_q[0]  <= fdct_pkg::mulc(t13_q, fdct_pkg::C_0541 + fdct_pkg::C_0765);
      p_q[1]  <= fdct_pkg::mulc(t12_q, fdct_pkg::C_0541);
      p_q[2]  <= fdct_pkg::mulc(t12_q, fdct_pkg::C_0541 - fdct_pkg::C_1847);
      p_q[3]  <= fdct_pkg::mulc(t13_q, fdct_pkg::C_0541);
      p_q[4]  <= fdct_pkg::mulc(za_q, fdct_pkg::C_1175 - fdct_pkg::C_1961);
      p_q[5]  <= fdct_pkg::mulc(zb_q, fdct_pkg::C_1175);
      p_q[6]  <= fdct_pkg::mulc(zb_q, fdct_pkg::C_1175 - fdct_pkg::C_0390);
      p_q[7]  <= fdct_pkg::mulc(za_q, fdct_pkg::C_1175);
      p_q[8]  <= fdct_pkg::mulc(t4_q, fdct_pkg::C_0298 - fdct_pkg::C_0899);
      p_q[9]  <= fdct_pkg::mulc(t7_q, fdct_pkg::C_0899);
      p_q[10] <= fdct_pkg::mulc(t5_q, fdct_pkg::C_2053 - fdct_pkg::C_2562);
      p_q[11] <= fdct_pkg::mulc(t6_q, fdct_pkg::C_2562);
      p_q[12] <= fdct_pkg::mulc(t6_q, fdct_pkg::C_3072 - fdct_pkg::C_2562);
      p_q[13] <= fdct_pkg::mulc(t5_q, fdct_pkg::C_2562);
      p_q[14] <= fdct_pkg::mulc(t7_q, fdct_pkg::C_1501 - fdct_pkg::C_0899);
      p_q[15] <= fdct_pkg::mulc(t4_q, fdct_pkg::C_0899);
    end
  end

  assign z3 = p_q[4] + p_q[5];
  assign z4 = p_q[6] + p_q[7];

  // DC and Nyquist terms: scale up in the row pass, round and scale down in the column pass.
  always_comb begin
    logic signed [15:0] s0, s4;
    s0 = dc0b_q + 16'sd2;
    s4 = dc4b_q + 16'sd2;
    if (sec2_q) begin
      e0 = s0 >>> fdct_pkg::PASS1_BITS;
      e4 = s4 >>> fdct_pkg::PASS1_BITS;
    end else begin
      e0 = {dc0b_q[13:0], 2'b00};
      e4 = {dc4b_q[13:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      vec_o[0] <= e0;
      vec_o[4] <= e4;
      vec_o[2] <= fdct_pkg::descale(p_q[0] + p_q[1], sec2_q);
      vec_o[6] <= fdct_pkg::descale(p_q[2] + p_q[3], sec2_q);
      vec_o[7] <= fdct_pkg::descale(p_q[8] - p_q[9] + z3, sec2_q);
      vec_o[5] <= fdct_pkg::descale(p_q[10] - p_q[11] + z4, sec2_q);
      vec_o[3] <= fdct_pkg::descale(p_q[12] - p_q[13] + z3, sec2_q);
      vec_o[1] <= fdct_pkg::descale(p_q[14] - p_q[15] + z4, sec2_q);
    end
  end

  assign valid_o = v3_q;
endmodule
`default_nettype wire

### rtl/core/forward_dct_8x8_islow_top.sv
// Top level of the 8x8 slow-integer forward DCT: sequencer around one RAM.
// Depends on fdct_pkg, fdct_ram and fdct_core.
//
// Usage: present one row of eight signed 8-bit samples on req_i with start
// high; the request is taken at a rising edge where start is high and busy
// is low. Rows arrive in order 0..7.
// Each row runs through the three-stage DCT unit and its eight results are
// written to the RAM one word a cycle; busy stays high until the last word
// is written, so no new row is taken before then. After the eighth row the
// column pass gathers each column from the RAM, transforms it and writes
// eight coefficients back; then the eight coefficient rows are read out.
// Busy stays high until the last coefficient row has been shown.
// Each coefficient row is shown for one cycle with res_strobe_o high, in
// vertical frequency order; block_done marks the last. The receiver cannot
// stall. Reset returns the row counter to zero; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module forward_dct_8x8_islow_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire fdct_pkg::req_t req_i,
  output logic                res_strobe_o,
  output fdct_pkg::res_t      res_o
);
  localparam int unsigned AW = $clog2(fdct_pkg::RAM_DEPTH);

  fdct_pkg::state_e state_q, state_d;
  logic [3:0] cnt_q;
  logic [2:0] row_q, col_q;
  logic       second_q, go_q;
  fdct_pkg::vec_t vec_q, core_out;
  logic       core_valid;
  logic           ram_we;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata, rdata;

  fdct_ram #(.Width(fdct_pkg::DATA_W), .Depth(fdct_pkg::RAM_DEPTH)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  fdct_core u_core (
    .clk_i, .rst_ni, .valid_i(go_q), .second_i(second_q), .vec_i(vec_q),
    .valid_o(core_valid), .vec_o(core_out)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      fdct_pkg::ST_IDLE:   if (start) state_d = fdct_pkg::ST_CALC;
      fdct_pkg::ST_CALC:   if (core_valid) state_d = fdct_pkg::ST_WR;
      fdct_pkg::ST_WR: begin
        if (cnt_q[2:0] == 3'd7) begin
          if (!second_q) begin
            state_d = (row_q == 3'd7) ? fdct_pkg::ST_GATHER : fdct_pkg::ST_IDLE;
          end else begin
            state_d = (col_q == 3'd7) ? fdct_pkg::ST_OUTRD : fdct_pkg::ST_GATHER;
          end
        end
      end
      fdct_pkg::ST_GATHER: if (cnt_q == 4'd8) state_d = fdct_pkg::ST_CALC;
      fdct_pkg::ST_OUTRD:  if (cnt_q == 4'd8) state_d = fdct_pkg::ST_EMIT;
      fdct_pkg::ST_EMIT:   state_d = (col_q == 3'd7) ? fdct_pkg::ST_IDLE : fdct_pkg::ST_OUTRD;
      default:             state_d = fdct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_q != fdct_pkg::ST_IDLE);
    ram_we       = 1'b0;
    waddr        = {1'b0, row_q, cnt_q[2:0]};
    wdata        = core_out[cnt_q[2:0]];
    raddr        = {1'b0, cnt_q[2:0], col_q};
    res_strobe_o = 1'b0;
    case (state_q)
      fdct_pkg::ST_WR: begin
        ram_we = 1'b1;
        if (second_q) waddr = {1'b1, cnt_q[2:0], col_q};
      end
      fdct_pkg::ST_OUTRD: raddr = {1'b1, col_q, cnt_q[2:0]};
      fdct_pkg::ST_EMIT:  res_strobe_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o = '{coef0: vec_q[0], coef1: vec_q[1], coef2: vec_q[2], coef3: vec_q[3],
                   coef4: vec_q[4], coef5: vec_q[5], coef6: vec_q[6], coef7: vec_q[7],
                   freq_row: col_q,
                   block_done: res_strobe_o && (col_q == 3'd7)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fdct_pkg::ST_IDLE;
      cnt_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      second_q <= 1'b0;
      go_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      // Launch the DCT unit on a row request or once a column is gathered.
      go_q    <= (state_q == fdct_pkg::ST_IDLE && start)
              || (state_q == fdct_pkg::ST_GATHER && cnt_q == 4'd8);
      case (state_q)
        fdct_pkg::ST_IDLE: begin
          if (start) begin
            second_q <= 1'b0;
          end
        end
        fdct_pkg::ST_CALC: cnt_q <= '0;
        fdct_pkg::ST_WR: begin
          if (cnt_q[2:0] == 3'd7) begin
            cnt_q <= '0;
            if (!second_q) begin
              row_q <= row_q + 3'd1;
              if (row_q == 3'd7) begin
                col_q    <= '0;
                second_q <= 1'b1;
              end
            end else begin
              col_q <= col_q + 3'd1;
            end
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        fdct_pkg::ST_GATHER: cnt_q <= cnt_q + 4'd1;
        fdct_pkg::ST_OUTRD:  cnt_q <= cnt_q + 4'd1;
        fdct_pkg::ST_EMIT: begin
          cnt_q <= '0;
          col_q <= col_q + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // Load the row on request; capture RAM data in the cycle after its read.
  always_ff @(posedge clk_i) begin
    if (state_q == fdct_pkg::ST_IDLE && start) begin
      vec_q[0] <= 16'(req_i.sample0);
      vec_q[1] <= 16'(req_i.sample1);
      vec_q[2] <= 16'(req_i.sample2);
      vec_q[3] <= 16'(req_i.sample3);
      vec_q[4] <= 16'(req_i.sample4);
      vec_q[5] <= 16'(req_i.sample5);
      vec_q[6] <= 16'(req_i.sample6);
      vec_q[7] <= 16'(req_i.sample7);
    end else if ((state_q == fdct_pkg::ST_GATHER || state_q == fdct_pkg::ST_OUTRD)
                 && cnt_q != 4'd0) begin
      vec_q[3'(cnt_q - 4'd1)] <= rdata;
    end
  end

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> busy) else $error("result strobe while idle");
  a_done_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.block_done |-> (res_strobe_o && res_o.freq_row == 3'd7))
    else $error("block_done off the last row");
  a_no_wr_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && res_strobe_o)) else $error("write during emit");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not taken");
endmodule
`default_nettype wire

### bench/forward_dct_8x8_islow_top_test.sv
// Self-checking bench for the 8x8 slow-integer forward DCT top level.
// Drives sample rows with random gaps and compares coefficient rows with a local transform.
// Depends on fdct_pkg and forward_dct_8x8_islow_top.
`timescale 1ns / 1ps
module forward_dct_8x8_islow_top_test;

  localparam int NUM_RANDOM = 360;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRESSURE_AT = 152;

  typedef struct {
    fdct_pkg::req_t     row;
    bit                 typed;
    logic signed [15:0] dc;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  fdct_pkg::req_t req_i;
  logic res_strobe_o;
  fdct_pkg::res_t res_o;

  forward_dct_8x8_islow_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .res_strobe_o(res_strobe_o), .res_o(res_o)
  );

  fdct_pkg::res_t coef_rows_q[$];
  int   row_pos;
  int   row_store[64];
  int   err_count;
  int   rows_checked;
  int   cycles;
  dir_row_t dir_tab[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int wrap16(input longint v);
    return int'(shortint'(v));
  endfunction

  function automatic int descale_by(input longint v, input int sh);
    return wrap16((v + (longint'(1) << (sh - 1))) >>> sh);
  endfunction

  function automatic int dc_term(input int s, input bit second);
    if (!second) return wrap16(longint'(s) * 4);
    return int'(longint'(wrap16(longint'(s) + 2)) >>> 2);
  endfunction

  // One 8-point Loeffler transform with 16-bit wrapping butterflies.
  task automatic dct8(input int d[8], output int o[8], input bit second);
    int sh, t0, t1, t2, t3, t4, t5, t6, t7, t10, t11, t12, t13, za, zb;
    longint z3, z4;
    sh  = second ? 15 : 11;
    t0  = wrap16(d[0] + d[7]);
    t7  = wrap16(d[0] - d[7]);
    t1  = wrap16(d[1] + d[6]);
    t6  = wrap16(d[1] - d[6]);
    t2  = wrap16(d[2] + d[5]);
    t5  = wrap16(d[2] - d[5]);
    t3  = wrap16(d[3] + d[4]);
    t4  = wrap16(d[3] - d[4]);
    t10 = wrap16(t0 + t3);
    t13 = wrap16(t0 - t3);
    t11 = wrap16(t1 + t2);
    t12 = wrap16(t1 - t2);
    o[0] = dc_term(wrap16(t10 + t11), second);
    o[4] = dc_term(wrap16(t10 - t11), second);
    o[2] = descale_by(longint'(t13) * (4433 + 6270) + longint'(t12) * 4433, sh);
    o[6] = descale_by(longint'(t12) * (4433 - 15137) + longint'(t13) * 4433, sh);
    za = wrap16(t4 + t6);
    zb = wrap16(t5 + t7);
    z3 = longint'(za) * (9633 - 16069) + longint'(zb) * 9633;
    z4 = longint'(zb) * (9633 - 3196) + longint'(za) * 9633;
    o[7] = descale_by(longint'(t4) * (2446 - 7373) - longint'(t7) * 7373 + z3, sh);
    o[5] = descale_by(longint'(t5) * (16819 - 20995) - longint'(t6) * 20995 + z4, sh);
    o[3] = descale_by(longint'(t6) * (25172 - 20995) - longint'(t5) * 20995 + z3, sh);
    o[1] = descale_by(longint'(t7) * (12299 - 7373) - longint'(t4) * 7373 + z4, sh);
  endtask

  // Run pass 1 on the row; on the eighth row run pass 2 and queue eight coefficient rows.
  task automatic predict_row(input fdct_pkg::req_t r);
    int d[8], o[8], col[8], fc[8];
    int coef[64];
    fdct_pkg::res_t e;
    d = '{r.sample0, r.sample1, r.sample2, r.sample3,
          r.sample4, r.sample5, r.sample6, r.sample7};
    dct8(d, o, 1'b0);
    for (int j = 0; j < 8; j++) row_store[row_pos * 8 + j] = o[j];
    if (row_pos != 7) begin
      row_pos++;
      return;
    end
    row_pos = 0;
    for (int c = 0; c < 8; c++) begin
      for (int k = 0; k < 8; k++) col[k] = row_store[k * 8 + c];
      dct8(col, fc, 1'b1);
      for (int k = 0; k < 8; k++) coef[k * 8 + c] = fc[k];
    end
    for (int k = 0; k < 8; k++) begin
      e = '0;
      for (int c = 0; c < 8; c++) e[131 - 16 * c -: 16] = 16'(coef[k * 8 + c]);
      e.freq_row   = 3'(k);
      e.block_done = (k == 7);
      coef_rows_q.push_back(e);
    end
  endtask

  // Replace the last eight predictions with a flat block: only coef0 of row 0 can be nonzero.
  task automatic set_flat_block(input logic signed [15:0] dc);
    fdct_pkg::res_t e;
    repeat (8) void'(coef_rows_q.pop_back());
    for (int k = 0; k < 8; k++) begin
      e = '0;
      if (k == 0) e.coef0 = dc;
      e.freq_row   = 3'(k);
      e.block_done = (k == 7);
      coef_rows_q.push_back(e);
    end
  endtask

  function automatic fdct_pkg::req_t flat_row(input logic signed [7:0] v);
    return '{v, v, v, v, v, v, v, v};
  endfunction

  function automatic logic [7:0] rand_sample();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return 8'h7f;
    if (m == 1) return 8'h80;
    if (m == 2) return 8'(32'($urandom_range(0, 6)) - 3);
    return 8'($urandom);
  endfunction

  task automatic send_row(input fdct_pkg::req_t r);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_row(r);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) begin
      if (coef_rows_q.size() == 0) begin
        $error("coefficient row with no request pending: freq_row %0d", res_o.freq_row);
        err_count++;
      end else begin
        fdct_pkg::res_t e;
        e = coef_rows_q.pop_front();
        rows_checked++;
        for (int c = 0; c < 8; c++) begin
          if (res_o[131 - 16 * c -: 16] !== e[131 - 16 * c -: 16]) begin
            $error("coef%0d: expected %0d, got %0d", c,
                   $signed(e[131 - 16 * c -: 16]), $signed(res_o[131 - 16 * c -: 16]));
            err_count++;
          end
        end
        if (res_o.freq_row !== e.freq_row) begin
          $error("freq_row: expected %0d, got %0d", e.freq_row, res_o.freq_row);
          err_count++;
        end
        if (res_o.block_done !== e.block_done) begin
          $error("block_done: expected %0d, got %0d", e.block_done, res_o.block_done);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    fdct_pkg::req_t r;
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    row_pos = 0;
    err_count = 0;
    rows_checked = 0;
    cycles = 0;
    for (int i = 0; i < 64; i++) row_store[i] = 0;
    // Flat blocks at zero and both extremes; the results read straight off the DC term.
    for (int i = 0; i < 8; i++) dir_tab.push_back('{flat_row(8'sd0), i == 7, 16'sd0});
    for (int i = 0; i < 8; i++) dir_tab.push_back('{flat_row(8'sd127), i == 7, 16'sd8128});
    for (int i = 0; i < 8; i++) dir_tab.push_back('{flat_row(-8'sd128), i == 7, -16'sd8192});
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_row(dir_tab[i].row);
      if (dir_tab[i].typed) set_flat_block(dir_tab[i].dc);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == PRESSURE_AT) begin
        start <= 1'b0;
        while (coef_rows_q.size() != 0) @(posedge clk_i);
      end
      r = '{rand_sample(), rand_sample(), rand_sample(), rand_sample(),
            rand_sample(), rand_sample(), rand_sample(), rand_sample()};
      send_row(r);
    end
    start <= 1'b0;

    while (coef_rows_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("%0d sample rows sent, %0d coefficient rows checked",
             dir_tab.size() + NUM_RANDOM, rows_checked);
    $display("covered flat blocks at zero and both extremes, then random blocks");
    if (err_count == 0 && coef_rows_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### forward_dct_8x8_islow_top.f
rtl/core/fdct_pkg.sv
rtl/core/fdct_ram.sv
rtl/core/fdct_core.sv
rtl/core/forward_dct_8x8_islow_top.sv
bench/forward_dct_8x8_islow_top_test.sv
